FILE: rtl/core/rgbblur_pkg.sv
package rgbblur_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS = 11;
   localparam int ROW_BITS   = 13;

   // reset geometry
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 13'd480;

   // register indexes
   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'b1;

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;

   // reciprocal multipliers, exact for the sum ranges of corner and edge pixels
   localparam logic [9:0]  DIV3_MUL = 10'd683;
   localparam logic [10:0] DIV5_MUL = 11'd1639;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one request as it leaves the input register
   typedef struct packed {
      logic [COL_BITS-1:0] column;
      pixel_type           colour;
      logic                has_older;
      logic                has_newer;
      logic                line_write;
      logic                emit;
      logic                last;
      logic                top;
      logic                bottom;
      logic                left;
      logic                right;
   } stage_type;

   // floor of sum / 3 for sums up to 765
   function automatic logic [7:0] div3(input logic [10:0] sum);
      logic [20:0] prod;
      prod = 21'(sum) * 21'(DIV3_MUL);
      return prod[18:11];
   endfunction

   // floor of sum / 5 for sums up to 1275
   function automatic logic [7:0] div5(input logic [10:0] sum);
      logic [21:0] prod;
      prod = 22'(sum) * 22'(DIV5_MUL);
      return prod[20:13];
   endfunction

endpackage

FILE: rtl/core/rgb_box_blur_3x3_no_center.sv
// 3x3 neighbour mean of an RGB888 raster stream, centre pixel excluded: interior pixels
// average 8 neighbours, edges 5, corners 3, each channel floored. One request is taken
// every clock while req_stall is low; a request goes through an input register (which also
// holds the line-store read) and a result register. The first result of a frame comes with
// the request one row plus one pixel into the frame; after the last pixel, width + 1 drain
// requests (kind 1, or any request) flush the remaining results, and the last one carries
// frame_end. Drain requests sent while pixels are expected are dropped. Width and height
// are clamped to [2, 1024] and [2, 4096]; writing either register restarts the frame and
// may only be done while idle. The line stores are a single 1024 x 48 memory, read once
// and written at most once per request; rows not yet written in a frame read as black, so
// no clearing pass follows reset.
module rgb_box_blur_3x3_no_center (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [rgbblur_pkg::ROW_BITS-1:0] csr_data
);
   import rgbblur_pkg::*;

   logic [WIDTH_BITS-1:0] width_ff;
   logic [ROW_BITS-1:0]   height_ff;
   logic [COL_BITS-1:0]   in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]   in_row_ff, in_row_in;
   logic                  s1_valid_ff, s1_valid_in;
   stage_type             s1_ff, s0;
   logic [47:0]           line_mem [MAX_WIDTH];
   logic [47:0]           line_rd_ff;
   pixel_type             win_ff [3][2];
   logic                  rsp_valid_ff;
   pixel_type             rsp_pix_ff;
   logic                  rsp_end_ff;

   logic                  csr_write, accept, draining, take, out_free, s1_fire;
   logic [WIDTH_BITS-1:0] col_next;
   pixel_type             new_col [3];
   pixel_type             view [3][3];
   logic [10:0]           sum_r, sum_g, sum_b;
   pixel_type             result;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // configuration, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (csr_data[WIDTH_BITS-1:0] < 11'd2)
                  width_ff <= 11'd2;
               else if (csr_data[WIDTH_BITS-1:0] > WIDTH_BITS'(MAX_WIDTH))
                  width_ff <= WIDTH_BITS'(MAX_WIDTH);
               else
                  width_ff <= csr_data[WIDTH_BITS-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_data < 13'd2)
                  height_ff <= 13'd2;
               else if (csr_data > ROW_BITS'(MAX_HEIGHT))
                  height_ff <= ROW_BITS'(MAX_HEIGHT);
               else
                  height_ff <= csr_data;
            end
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire   = s1_valid_ff & (~s1_ff.emit | out_free);
   assign req_stall = s1_valid_ff & ~s1_fire;
   assign accept    = req_valid & ~req_stall;

   // position decode for the incoming request
   assign draining = (in_row_ff >= height_ff);
   assign take     = accept & (draining | (req_kind == KIND_PIXEL));

   always_comb begin
      s0.column     = in_col_ff;
      s0.colour     = draining ? '0 : pixel_type'{req_red, req_green, req_blue};
      s0.has_older  = (in_row_ff >= 13'd2);
      s0.has_newer  = (in_row_ff >= 13'd1);
      s0.line_write = (in_row_ff < height_ff);
      s0.right      = (in_col_ff == '0);
      s0.left       = (in_col_ff == COL_BITS'(1));
      s0.last       = s0.right & (in_row_ff == height_ff + 13'd1);
      if (s0.right) begin
         s0.emit   = (in_row_ff >= 13'd2);
         s0.top    = (in_row_ff == 13'd2);
         s0.bottom = (in_row_ff > height_ff);
      end else begin
         s0.emit   = (in_row_ff >= 13'd1);
         s0.top    = (in_row_ff == 13'd1);
         s0.bottom = (in_row_ff >= height_ff);
      end
   end

   // input position counters
   assign col_next = {1'b0, in_col_ff} + 11'd1;

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (csr_write || (take && s0.last)) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (take) begin
         if (col_next >= width_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 13'd1;
         end else begin
            in_col_in = col_next[COL_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (accept)
         s1_valid_in = take;
      else if (s1_fire)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept)
         s1_ff <= s0;
   end

   // line stores: older row in the upper half, newer row in the lower half
   always_ff @(posedge clock) begin
      if (accept)
         line_rd_ff <= line_mem[in_col_ff];
      if (s1_fire && s1_ff.line_write)
         line_mem[s1_ff.column] <= {line_rd_ff[23:0], s1_ff.colour};
   end

   // new window column and the neighbourhood seen by the result
   always_comb begin
      new_col[0] = s1_ff.has_older ? pixel_type'(line_rd_ff[47:24]) : '0;
      new_col[1] = s1_ff.has_newer ? pixel_type'(line_rd_ff[23:0]) : '0;
      new_col[2] = s1_ff.colour;
      for (int r = 0; r < 3; r++) begin
         view[r][0] = win_ff[r][0];
         view[r][1] = win_ff[r][1];
         view[r][2] = new_col[r];
      end
   end

   // window, two stored columns plus the incoming one
   always_ff @(posedge clock) begin
      if (reset || csr_write || (s1_fire && s1_ff.last)) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= '0;
            win_ff[r][1] <= '0;
         end
      end else if (s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= new_col[r];
         end
      end
   end

   // masked neighbour sums
   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1) && !(r == 0 && s1_ff.top) && !(r == 2 && s1_ff.bottom)
                && !(c == 0 && s1_ff.left) && !(c == 2 && s1_ff.right)) begin
               sum_r = sum_r + 11'(view[r][c].red);
               sum_g = sum_g + 11'(view[r][c].green);
               sum_b = sum_b + 11'(view[r][c].blue);
            end
         end
      end
   end

   // divide by neighbour count: corner 3, edge 5, interior 8
   always_comb begin
      if ((s1_ff.top | s1_ff.bottom) && (s1_ff.left | s1_ff.right)) begin
         result = pixel_type'{div3(sum_r), div3(sum_g), div3(sum_b)};
      end else if (s1_ff.top | s1_ff.bottom | s1_ff.left | s1_ff.right) begin
         result = pixel_type'{div5(sum_r), div5(sum_g), div5(sum_b)};
      end else begin
         result = pixel_type'{sum_r[10:3], sum_g[10:3], sum_b[10:3]};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (s1_fire && s1_ff.emit)
         rsp_valid_ff <= 1'b1;
      else if (~rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.emit) begin
         rsp_pix_ff <= result;
         rsp_end_ff <= s1_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_frame_end = rsp_end_ff;

   // input column never reaches the row width
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, in_col_ff} < width_ff)
      else $error("input column out of range");

   // input row never passes the drain row
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= height_ff + 13'd1)
      else $error("input row out of range");

   // a result-producing request always lands in the result register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ff.emit) |=> rsp_valid)
      else $error("result lost");

   // a register write leaves the window cleared
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (win_ff[1][0] == '0 && win_ff[1][1] == '0 && in_row_ff == '0))
      else $error("restart after register write incomplete");

   // the frame end result follows only the last position of the frame
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ff.last) |-> (s1_ff.bottom && s1_ff.right && s1_ff.emit))
      else $error("frame end outside the bottom right corner");

endmodule
